// ----- rtl/dual_axis_pid_position_loop_macros.svh -----
// Assertion macros for the dual-axis PID position loop.
`ifndef DUAL_AXIS_PID_POSITION_LOOP_MACROS_SVH
`define DUAL_AXIS_PID_POSITION_LOOP_MACROS_SVH
`ifndef SYNTH
`define DAPID_ASSERT_NEVER(label, clk, rst, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);
`define DAPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define DAPID_ASSERT_NEVER(label, clk, rst, cond, msg)
`define DAPID_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

// ----- rtl/dapid_pkg.sv -----
// Package: constants, codes and types of the dual-axis PID position loop.
`default_nettype none
package dapid_pkg;
  localparam logic [15:0] DT_MAX_US = 16'd20000;
  localparam logic [27:0] I_DIVISOR = 28'd256000000;
  localparam logic [31:0] US_PER_S = 32'd1000000;
  localparam logic [31:0] ALPHA_Q16 = 32'd9830;
  localparam logic [31:0] ONE_MINUS_ALPHA_Q16 = 32'd55706;

  typedef enum logic [2:0] {
    CFG_GAINS_PAN, CFG_GAINS_TILT, CFG_INTEG_LIM_PAN, CFG_INTEG_LIM_TILT,
    CFG_DZ_PAN, CFG_DZ_TILT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_ERR, ST_P, ST_I1, ST_I2, ST_I3, ST_R1, ST_R2,
    ST_F1, ST_F2, ST_D, ST_OUT
  } state_t;

  typedef struct packed {
    logic        start;
    logic [31:0] a;
    logic [31:0] b;
  } mul_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] prod;
  } mul_rsp_t;

  typedef struct packed {
    logic        start;
    logic [47:0] n;
    logic [27:0] d;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [47:0] q;
    logic        rem_nz;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/dapid_mul.sv -----
// Bit-serial 32x32 unsigned multiplier, one multiplier bit per cycle.
`default_nettype none
module dapid_mul (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dapid_pkg::mul_req_t req,
  output dapid_pkg::mul_rsp_t      rsp
);
  logic        busy;
  logic        done;
  logic [4:0]  cnt;
  logic [31:0] a_r;
  logic [31:0] hi;
  logic [31:0] lo;
  logic [32:0] sum;

  assign sum = {1'b0, hi} + (lo[0] ? {1'b0, a_r} : 33'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
        a_r  <= req.a;
        hi   <= 32'd0;
        lo   <= req.b;
      end else if (busy) begin
        hi  <= sum[32:1];
        lo  <= {sum[0], lo[31:1]};
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.prod = {hi, lo};
endmodule
`default_nettype wire

// ----- rtl/dapid_div.sv -----
// Restoring divider, 48-bit dividend by 28-bit divisor, one quotient bit per cycle.
`default_nettype none
module dapid_div (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire dapid_pkg::div_req_t req,
  output dapid_pkg::div_rsp_t      rsp
);
  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [47:0] qn;
  logic [27:0] rem;
  logic [27:0] d_r;
  logic [28:0] shifted;
  logic [28:0] diff;
  logic        ge;

  assign shifted = {rem, qn[47]};
  assign ge      = shifted >= {1'b0, d_r};
  assign diff    = shifted - {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= 6'd0;
        qn   <= req.n;
        rem  <= 28'd0;
        d_r  <= req.d;
      end else if (busy) begin
        rem <= ge ? diff[27:0] : shifted[27:0];
        qn  <= {qn[46:0], ge};
        cnt <= cnt + 6'd1;
        if (cnt == 6'd47) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done   = done;
  assign rsp.q      = qn;
  assign rsp.rem_nz = rem != 28'd0;
endmodule
`default_nettype wire

// ----- rtl/dual_axis_pid_position_loop.sv -----
// Top level: dual-axis PID position loop with low-passed derivative.
//
// One item in gives one result out. A tick with dt_us of 0 or above 20000
// returns the held commands and errors with updated low; its result is
// offered the cycle after acceptance. A valid tick steps pan then tilt; each
// axis first forms the error, then makes seven passes through the bit-serial
// multiplier and two through the serial divider; the result is offered once
// the tilt axis is done, and no new item is accepted until it is taken.
// in_stall stays high from acceptance until the result is taken.
`default_nettype none
`include "dual_axis_pid_position_loop_macros.svh"
module dual_axis_pid_position_loop (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [47:0]        cfg_data,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [15:0]        target_pan,
  input  wire logic [15:0]        target_tilt,
  input  wire logic [15:0]        current_pan,
  input  wire logic [15:0]        current_tilt,
  input  wire logic [15:0]        dt_us,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [31:0]      vel_cmd_pan,
  output logic signed [31:0]      vel_cmd_tilt,
  output logic signed [15:0]      error_pan,
  output logic signed [15:0]      error_tilt,
  output logic                    updated
);
  dapid_pkg::state_t   state, state_next;
  dapid_pkg::mul_req_t mul_req;
  dapid_pkg::mul_rsp_t mul_rsp;
  dapid_pkg::div_req_t div_req;
  dapid_pkg::div_rsp_t div_rsp;

  logic [47:0] gains_pan, gains_tilt;
  logic [30:0] integ_lim_pan, integ_lim_tilt;
  logic [14:0] dz_pan, dz_tilt;

  logic [31:0] integ_acc [2];
  logic [15:0] prev_err [2];
  logic [31:0] filt_der [2];
  logic [31:0] held_cmd [2];
  logic [15:0] held_err [2];

  logic [15:0] tgt_r [2];
  logic [15:0] cur_r [2];
  logic [15:0] dt_r;
  logic        ax;
  logic        updated_r;
  logic [15:0] eff_r;
  logic [15:0] eff_mag_r;
  logic [31:0] integ_w;
  logic [31:0] fd_w;
  logic [31:0] p_r;
  logic [48:0] t1;
  logic        mneg, mneg_next;

  logic        dt_ok;
  logic [47:0] gain_c;
  logic [30:0] imax_c;
  logic [14:0] dz_c;
  logic [15:0] e_c;
  logic [16:0] e_mag;
  logic [15:0] eff_c;
  logic [15:0] eff_mag_c;
  logic [63:0] sprod;
  logic [16:0] diff_c;
  logic [16:0] dmag;
  logic [48:0] iq_mag;
  logic [33:0] iq_s;
  logic [33:0] integ_sum;
  logic [33:0] imax_pos;
  logic [33:0] imax_neg;
  logic [31:0] integ_clamp;
  logic [31:0] rmag;
  logic [31:0] fdmag;
  logic [49:0] fsum;
  logic [31:0] filt;
  logic [31:0] filt_mag;
  logic [41:0] cmd_sum;
  logic [31:0] cmd_sat;

  dapid_mul u_mul (.clk(clk), .rst(rst), .req(mul_req), .rsp(mul_rsp));
  dapid_div u_div (.clk(clk), .rst(rst), .req(div_req), .rsp(div_rsp));

  assign dt_ok = (dt_us != 16'd0) && (dt_us <= dapid_pkg::DT_MAX_US);

  assign gain_c    = ax ? gains_tilt : gains_pan;
  assign imax_c    = ax ? integ_lim_tilt : integ_lim_pan;
  assign dz_c      = ax ? dz_tilt : dz_pan;
  assign e_c       = tgt_r[ax] - cur_r[ax];
  assign e_mag     = e_c[15] ? (17'h10000 - {1'b0, e_c}) : {1'b0, e_c};
  assign eff_c     = (e_mag < {2'b00, dz_c}) ? 16'd0 : e_c;
  assign eff_mag_c = (eff_c == 16'd0) ? 16'd0 : e_mag[15:0];

  assign sprod  = mneg ? (~mul_rsp.prod + 64'd1) : mul_rsp.prod;
  assign diff_c = {eff_r[15], eff_r} - {prev_err[ax][15], prev_err[ax]};
  assign dmag   = diff_c[16] ? (~diff_c + 17'd1) : diff_c;

  assign iq_mag    = {1'b0, div_rsp.q} + {48'd0, div_rsp.rem_nz & mneg};
  assign iq_s      = mneg ? (~iq_mag[33:0] + 34'd1) : iq_mag[33:0];
  assign integ_sum = {{2{integ_w[31]}}, integ_w} + iq_s;
  assign imax_pos  = {3'b000, imax_c};
  assign imax_neg  = ~imax_pos + 34'd1;

  always_comb begin
    if ($signed(integ_sum) > $signed(imax_pos)) begin
      integ_clamp = {1'b0, imax_c};
    end else if ($signed(integ_sum) < $signed(imax_neg)) begin
      integ_clamp = imax_neg[31:0];
    end else begin
      integ_clamp = integ_sum[31:0];
    end
  end

  always_comb begin
    if (mneg) begin
      rmag = (div_rsp.q > 48'h80000000) ? 32'h80000000 : div_rsp.q[31:0];
    end else begin
      rmag = (div_rsp.q > 48'h7FFFFFFF) ? 32'h7FFFFFFF : div_rsp.q[31:0];
    end
  end

  assign fdmag    = fd_w[31] ? (~fd_w + 32'd1) : fd_w;
  assign fsum     = {t1[48], t1} + {sprod[48], sprod[48:0]};
  assign filt     = fsum[47:16];
  assign filt_mag = filt[31] ? (~filt + 32'd1) : filt;

  assign cmd_sum = {{10{p_r[31]}}, p_r} + {{10{integ_w[31]}}, integ_w}
                 + {{2{sprod[47]}}, sprod[47:8]};

  always_comb begin
    if ($signed(cmd_sum) > $signed(42'sh7FFFFFFF)) begin
      cmd_sat = 32'h7FFFFFFF;
    end else if ($signed(cmd_sum) < -$signed(42'sh80000000)) begin
      cmd_sat = 32'h80000000;
    end else begin
      cmd_sat = cmd_sum[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dapid_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    mneg_next     = mneg;
    mul_req.start = 1'b0;
    mul_req.a     = 32'd0;
    mul_req.b     = 32'd0;
    div_req.start = 1'b0;
    div_req.n     = mul_rsp.prod[47:0];
    div_req.d     = dapid_pkg::I_DIVISOR;
    case (state)
      dapid_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_next = dt_ok ? dapid_pkg::ST_ERR : dapid_pkg::ST_OUT;
        end
      end
      dapid_pkg::ST_ERR: begin
        mul_req.start = 1'b1;
        mul_req.a     = {16'd0, gain_c[15:0]};
        mul_req.b     = {16'd0, eff_mag_c};
        mneg_next     = eff_c[15];
        state_next    = dapid_pkg::ST_P;
      end
      dapid_pkg::ST_P: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {16'd0, gain_c[31:16]};
          mul_req.b     = {16'd0, eff_mag_r};
          mneg_next     = eff_r[15];
          state_next    = dapid_pkg::ST_I1;
        end
      end
      dapid_pkg::ST_I1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = mul_rsp.prod[31:0];
          mul_req.b     = {16'd0, dt_r};
          state_next    = dapid_pkg::ST_I2;
        end
      end
      dapid_pkg::ST_I2: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          state_next    = dapid_pkg::ST_I3;
        end
      end
      dapid_pkg::ST_I3: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = dapid_pkg::US_PER_S;
          mul_req.b     = {15'd0, dmag};
          mneg_next     = diff_c[16];
          state_next    = dapid_pkg::ST_R1;
        end
      end
      dapid_pkg::ST_R1: begin
        if (mul_rsp.done) begin
          div_req.start = 1'b1;
          div_req.d     = {12'd0, dt_r};
          state_next    = dapid_pkg::ST_R2;
        end
      end
      dapid_pkg::ST_R2: begin
        if (div_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = dapid_pkg::ALPHA_Q16;
          mul_req.b     = rmag;
          state_next    = dapid_pkg::ST_F1;
        end
      end
      dapid_pkg::ST_F1: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = dapid_pkg::ONE_MINUS_ALPHA_Q16;
          mul_req.b     = fdmag;
          mneg_next     = fd_w[31];
          state_next    = dapid_pkg::ST_F2;
        end
      end
      dapid_pkg::ST_F2: begin
        if (mul_rsp.done) begin
          mul_req.start = 1'b1;
          mul_req.a     = {16'd0, gain_c[47:32]};
          mul_req.b     = filt_mag;
          mneg_next     = filt[31];
          state_next    = dapid_pkg::ST_D;
        end
      end
      dapid_pkg::ST_D: begin
        if (mul_rsp.done) begin
          state_next = ax ? dapid_pkg::ST_OUT : dapid_pkg::ST_ERR;
        end
      end
      dapid_pkg::ST_OUT: begin
        if (!out_stall) begin
          state_next = dapid_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = dapid_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gains_pan      <= 48'd0;
      gains_tilt     <= 48'd0;
      integ_lim_pan  <= 31'd0;
      integ_lim_tilt <= 31'd0;
      dz_pan         <= 15'd0;
      dz_tilt        <= 15'd0;
    end else if (cfg_we) begin
      case (dapid_pkg::cfg_reg_t'(cfg_index))
        dapid_pkg::CFG_GAINS_PAN:      gains_pan      <= cfg_data;
        dapid_pkg::CFG_GAINS_TILT:     gains_tilt     <= cfg_data;
        dapid_pkg::CFG_INTEG_LIM_PAN:  integ_lim_pan  <= cfg_data[30:0];
        dapid_pkg::CFG_INTEG_LIM_TILT: integ_lim_tilt <= cfg_data[30:0];
        dapid_pkg::CFG_DZ_PAN:         dz_pan         <= cfg_data[14:0];
        dapid_pkg::CFG_DZ_TILT:        dz_tilt        <= cfg_data[14:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      integ_acc[0] <= 32'd0;
      integ_acc[1] <= 32'd0;
      prev_err[0]  <= 16'd0;
      prev_err[1]  <= 16'd0;
      filt_der[0]  <= 32'd0;
      filt_der[1]  <= 32'd0;
      held_cmd[0]  <= 32'd0;
      held_cmd[1]  <= 32'd0;
      held_err[0]  <= 16'd0;
      held_err[1]  <= 16'd0;
      updated_r    <= 1'b0;
      ax           <= 1'b0;
      mneg         <= 1'b0;
    end else begin
      mneg <= mneg_next;
      case (state)
        dapid_pkg::ST_IDLE: begin
          if (in_valid) begin
            tgt_r[0]  <= target_pan;
            tgt_r[1]  <= target_tilt;
            cur_r[0]  <= current_pan;
            cur_r[1]  <= current_tilt;
            dt_r      <= dt_us;
            ax        <= 1'b0;
            updated_r <= dt_ok;
          end
        end
        dapid_pkg::ST_ERR: begin
          eff_r        <= eff_c;
          eff_mag_r    <= eff_mag_c;
          held_err[ax] <= e_c;
          integ_w      <= (eff_c == 16'd0) ? 32'd0 : integ_acc[ax];
          fd_w         <= (eff_c == 16'd0) ? 32'd0 : filt_der[ax];
        end
        dapid_pkg::ST_P: begin
          if (mul_rsp.done) begin
            p_r <= sprod[39:8];
          end
        end
        dapid_pkg::ST_I3: begin
          if (div_rsp.done) begin
            integ_w <= integ_clamp;
          end
        end
        dapid_pkg::ST_F1: begin
          if (mul_rsp.done) begin
            t1 <= sprod[48:0];
          end
        end
        dapid_pkg::ST_F2: begin
          if (mul_rsp.done) begin
            fd_w <= filt;
          end
        end
        dapid_pkg::ST_D: begin
          if (mul_rsp.done) begin
            held_cmd[ax]  <= cmd_sat;
            integ_acc[ax] <= integ_w;
            filt_der[ax]  <= fd_w;
            prev_err[ax]  <= eff_r;
            ax            <= 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign in_stall     = state != dapid_pkg::ST_IDLE;
  assign out_valid    = state == dapid_pkg::ST_OUT;
  assign vel_cmd_pan  = held_cmd[0];
  assign vel_cmd_tilt = held_cmd[1];
  assign error_pan    = held_err[0];
  assign error_tilt   = held_err[1];
  assign updated      = updated_r;

  `DAPID_ASSERT_NEVER(a_no_accept_out, clk, rst, out_valid && !in_stall, "item taken")
  `DAPID_ASSERT_NEXT(a_out_clears, clk, rst, out_valid && !out_stall, !out_valid, "result repeated")
  `DAPID_ASSERT_NEVER(a_mul_idle, clk, rst, mul_rsp.done && (out_valid || !in_stall), "stray done")
endmodule
`default_nettype wire

// ----- verif/testbench.sv -----
// Testbench for the dual-axis PID position loop: table-driven and random ticks against a predictor.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] tp, tt, cp, ct, dt;
  } tick_t;

  typedef struct packed {
    logic signed [31:0] cmd_pan, cmd_tilt;
    logic signed [15:0] err_pan, err_tilt;
    logic               upd;
  } loop_out_t;

  typedef struct {
    tick_t     tick;
    bit        known;
    loop_out_t want;
  } tick_row_t;

  logic clk = 0;
  logic rst = 1;
  logic cfg_we = 0;
  logic [2:0] cfg_index = '0;
  logic [47:0] cfg_data = '0;
  logic in_valid = 0;
  logic in_stall;
  logic [15:0] target_pan = 0, target_tilt = 0, current_pan = 0, current_tilt = 0, dt_us = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [31:0] vel_cmd_pan, vel_cmd_tilt;
  logic signed [15:0] error_pan, error_tilt;
  logic updated;

  always #2 clk = ~clk;

  dual_axis_pid_position_loop dut (.*);

  longint gains_q [2];
  longint imax_q [2];
  longint dz_q [2];
  longint integ_q [2];
  longint prev_err_q [2];
  longint filt_q [2];
  longint held_cmd_q [2];
  longint held_err_q [2];

  loop_out_t pending_results [$];
  int fails = 0;
  int idle_cycles = 0;
  bit long_hold = 0;
  bit stim_done = 0;

  function automatic longint fdiv(longint a, longint b);
    longint q;
    q = a / b;
    if ((a % b) != 0 && a < 0) q -= 1;
    return q;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint axis_cmd(int ax, longint e, longint dt);
    longint kp, ki, kd, mag, eff, p, ig, raw, f, d;
    kp = gains_q[ax] & 16'hFFFF;
    ki = (gains_q[ax] >> 16) & 16'hFFFF;
    kd = (gains_q[ax] >> 32) & 16'hFFFF;
    mag = e < 0 ? -e : e;
    eff = (mag < dz_q[ax]) ? 0 : e;
    if (eff == 0) begin
      integ_q[ax] = 0;
      filt_q[ax] = 0;
    end
    p = fdiv(kp * eff, 256);
    ig = integ_q[ax] + fdiv(ki * eff * dt, 256000000);
    if (ig > imax_q[ax]) ig = imax_q[ax];
    if (ig < -imax_q[ax]) ig = -imax_q[ax];
    integ_q[ax] = ig;
    raw = sat32(((eff - prev_err_q[ax]) * 1000000) / dt);
    f = fdiv(9830 * raw + 55706 * filt_q[ax], 65536);
    filt_q[ax] = f;
    d = fdiv(kd * f, 256);
    prev_err_q[ax] = eff;
    return sat32(p + ig + d);
  endfunction

  function automatic loop_out_t predict_loop(tick_t t);
    loop_out_t r;
    logic [15:0] dp, dtl;
    r.upd = 0;
    if (t.dt != 0 && t.dt <= dapid_pkg::DT_MAX_US) begin
      dp = t.tp - t.cp;
      dtl = t.tt - t.ct;
      held_err_q[0] = longint'($signed(dp));
      held_err_q[1] = longint'($signed(dtl));
      held_cmd_q[0] = axis_cmd(0, held_err_q[0], longint'(t.dt));
      held_cmd_q[1] = axis_cmd(1, held_err_q[1], longint'(t.dt));
      r.upd = 1;
    end
    r.cmd_pan = held_cmd_q[0][31:0];
    r.cmd_tilt = held_cmd_q[1][31:0];
    r.err_pan = held_err_q[0][15:0];
    r.err_tilt = held_err_q[1][15:0];
    return r;
  endfunction

  task automatic write_reg(dapid_pkg::cfg_reg_t idx, logic [47:0] val);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 0;
    case (idx)
      dapid_pkg::CFG_GAINS_PAN: gains_q[0] = val;
      dapid_pkg::CFG_GAINS_TILT: gains_q[1] = val;
      dapid_pkg::CFG_INTEG_LIM_PAN: imax_q[0] = val[30:0];
      dapid_pkg::CFG_INTEG_LIM_TILT: imax_q[1] = val[30:0];
      dapid_pkg::CFG_DZ_PAN: dz_q[0] = val[14:0];
      default: dz_q[1] = val[14:0];
    endcase
  endtask

  task automatic drain;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic send_tick(tick_t t, bit known, loop_out_t want);
    loop_out_t p;
    target_pan <= t.tp;
    target_tilt <= t.tt;
    current_pan <= t.cp;
    current_tilt <= t.ct;
    dt_us <= t.dt;
    in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    p = predict_loop(t);
    if (known && p != want) begin
      $display("%0t table row mismatch: expected %h actual %h", $time, want, p);
      fails++;
    end
    pending_results.push_back(p);
  endtask

  task automatic send_gap;
    int g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 800) : $urandom_range(0, 3);
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  function automatic tick_t rand_tick(int mode);
    tick_t t;
    t.tp = 16'($urandom);
    t.cp = (mode == 0) ? t.tp + 16'($urandom_range(0, 600)) - 16'd300 : 16'($urandom);
    t.tt = 16'($urandom);
    t.ct = (mode == 0) ? t.tt + 16'($urandom_range(0, 600)) - 16'd300 : 16'($urandom);
    case ($urandom_range(0, 9))
      0: t.dt = 16'd0;
      1: t.dt = 16'($urandom_range(20001, 65535));
      2: t.dt = 16'($urandom_range(1, 3));
      3: t.dt = 16'd20000;
      default: t.dt = 16'($urandom_range(50, 5000));
    endcase
    return t;
  endfunction

  task automatic random_config;
    write_reg(dapid_pkg::CFG_GAINS_PAN, {16'($urandom), 16'($urandom), 16'($urandom)});
    write_reg(dapid_pkg::CFG_GAINS_TILT, {16'($urandom_range(0, 4096)), 16'($urandom),
                                          16'($urandom_range(0, 4096))});
    write_reg(dapid_pkg::CFG_INTEG_LIM_PAN, 48'($urandom));
    write_reg(dapid_pkg::CFG_INTEG_LIM_TILT, 48'($urandom_range(0, 100000)));
    write_reg(dapid_pkg::CFG_DZ_PAN, 48'($urandom_range(0, 50)));
    write_reg(dapid_pkg::CFG_DZ_TILT, ($urandom_range(0, 7) == 0) ? 48'h7FFF : 48'($urandom));
  endtask

  initial begin
    tick_row_t rows [$];
    tick_row_t row;
    loop_out_t z;
    int n;
    for (int i = 0; i < 2; i++) begin
      gains_q[i] = 0; imax_q[i] = 0; dz_q[i] = 0; integ_q[i] = 0;
      prev_err_q[i] = 0; filt_q[i] = 0; held_cmd_q[i] = 0; held_err_q[i] = 0;
    end
    repeat (3) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    z = '0;
    row.known = 1; row.want = z;
    row.tick = '{16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'd0}; rows.push_back(row);
    row.tick = '{16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'd20001}; rows.push_back(row);
    row.tick = '{16'h1234, 16'h0000, 16'h0000, 16'h0000, 16'hFFFF}; rows.push_back(row);
    row.want = '{32'sd0, 32'sd0, -16'sd1, 16'sd0, 1'b1};
    row.tick = '{16'h0000, 16'h0000, 16'h0001, 16'h0000, 16'd1}; rows.push_back(row);
    row.want = '{32'sd0, 32'sd0, -16'sh8000, 16'sh7FFF, 1'b1};
    row.tick = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'd20000}; rows.push_back(row);
    foreach (rows[i]) send_tick(rows[i].tick, 1, rows[i].want);
    in_valid <= 0;
    drain();

    write_reg(dapid_pkg::CFG_GAINS_PAN, 48'hFFFF_FFFF_FFFF);
    write_reg(dapid_pkg::CFG_GAINS_TILT, 48'h0100_0100_0100);
    write_reg(dapid_pkg::CFG_INTEG_LIM_PAN, 48'h7FFF_FFFF);
    write_reg(dapid_pkg::CFG_INTEG_LIM_TILT, 48'd1000);
    write_reg(dapid_pkg::CFG_DZ_PAN, 48'd0);
    write_reg(dapid_pkg::CFG_DZ_TILT, 48'h7FFF);
    rows.delete();
    row.known = 0;
    row.tick = '{16'h7FFF, 16'h0100, 16'h0000, 16'h0000, 16'd1}; rows.push_back(row);
    row.tick = '{16'h0000, 16'h0100, 16'h7FFF, 16'h0000, 16'd1}; rows.push_back(row);
    row.tick = '{16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'd1}; rows.push_back(row);
    row.tick = '{16'h8000, 16'h8000, 16'h0000, 16'h0000, 16'd20000}; rows.push_back(row);
    row.tick = '{16'h4000, 16'h8000, 16'h4000, 16'h0000, 16'd500}; rows.push_back(row);
    row.tick = '{16'h0010, 16'h0010, 16'h0000, 16'h0000, 16'd0}; rows.push_back(row);
    row.tick = '{16'h0010, 16'h0010, 16'h0000, 16'h0000, 16'd100}; rows.push_back(row);
    foreach (rows[i]) send_tick(rows[i].tick, 0, z);
    in_valid <= 0;
    drain();

    write_reg(dapid_pkg::CFG_DZ_PAN, 48'h7FFF);
    write_reg(dapid_pkg::CFG_INTEG_LIM_PAN, 48'd0);
    send_tick('{16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'd10}, 0, z);
    send_tick('{16'h7FFE, 16'h0000, 16'h0000, 16'h0000, 16'd10}, 0, z);
    in_valid <= 0;
    drain();

    n = 0;
    for (int phase = 0; phase < 5; phase++) begin
      random_config();
      for (int k = 0; k < 250; k++) begin
        send_tick(rand_tick(($urandom_range(0, 3) == 0) ? 1 : 0), 0, z);
        if (phase == 2 && k == 10) long_hold = 1;
        send_gap();
      end
      in_valid <= 0;
      drain();
    end
    stim_done = 1;
  end

  initial begin
    int g;
    forever begin
      @(posedge clk);
      if (long_hold) begin
        out_stall <= 1;
        repeat (3000) @(posedge clk);
        long_hold = 0;
        out_stall <= 0;
      end else if ($urandom_range(0, 3) == 0) begin
        g = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 400) : $urandom_range(1, 4);
        out_stall <= 1;
        repeat (g) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  always @(posedge clk) begin
    loop_out_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{vel_cmd_pan, vel_cmd_tilt, error_pan, error_tilt, updated};
      if (pending_results.size() == 0) begin
        $display("%0t unexpected result: actual %h", $time, got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.cmd_pan !== want.cmd_pan) begin
          $display("%0t vel_cmd_pan expected %0d actual %0d", $time, want.cmd_pan, got.cmd_pan);
          fails++;
        end
        if (got.cmd_tilt !== want.cmd_tilt) begin
          $display("%0t vel_cmd_tilt expected %0d actual %0d", $time, want.cmd_tilt,
                   got.cmd_tilt);
          fails++;
        end
        if (got.err_pan !== want.err_pan) begin
          $display("%0t error_pan expected %0d actual %0d", $time, want.err_pan, got.err_pan);
          fails++;
        end
        if (got.err_tilt !== want.err_tilt) begin
          $display("%0t error_tilt expected %0d actual %0d", $time, want.err_tilt, got.err_tilt);
          fails++;
        end
        if (got.upd !== want.upd) begin
          $display("%0t updated expected %0d actual %0d", $time, want.upd, got.upd);
          fails++;
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (stim_done) begin
        if (pending_results.size() != 0) begin
          $display("%0t %0d results never arrived", $time, pending_results.size());
          fails++;
        end
        if (fails == 0) begin
          $display("Simulation PASSED");
        end else begin
          $display("Simulation FAILED");
        end
        $finish;
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= 20000) begin
        $display("%0t watchdog timeout", $time);
        $display("Simulation FAILED");
        $finish;
      end
    end
  end
endmodule
`default_nettype wire

// ----- filelist.f -----
+incdir+rtl
rtl/dapid_pkg.sv
rtl/dapid_mul.sv
rtl/dapid_div.sv
rtl/dual_axis_pid_position_loop.sv
verif/testbench.sv
